// ===== design/tmc_pkg.sv =====
// Shared types, codes and reset constants for the transceiver mode controller.
`default_nettype none

package tmc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;

    localparam logic [15:0] FLOW_TIMEOUT_RST  = 16'd300;
    localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd3000;
    localparam logic [7:0]  REPORT_DIV_RST    = 8'd11;
    localparam logic [7:0]  LOW_BATTERY_RST   = 8'd60;

    localparam logic [1:0] CFG_FLOW_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_REPORT_DIV   = 2'd2;
    localparam logic [1:0] CFG_LOW_BATTERY  = 2'd3;

    localparam logic [2:0] FUNC_PACKET    = 3'd0;
    localparam logic [2:0] FUNC_EMPTY     = 3'd1;
    localparam logic [2:0] FUNC_START_TUN = 3'd2;
    localparam logic [2:0] FUNC_START_SCN = 3'd3;
    localparam logic [2:0] FUNC_STOP_SCN  = 3'd4;
    localparam logic [2:0] FUNC_POWER_OFF = 3'd5;
    localparam logic [2:0] FUNC_ACCESS    = 3'd6;

    localparam logic [1:0] NOTIFY_NONE = 2'd0;
    localparam logic [1:0] NOTIFY_TX   = 2'd1;
    localparam logic [1:0] NOTIFY_RX   = 2'd2;

    localparam logic [1:0] TCMD_NONE  = 2'd0;
    localparam logic [1:0] TCMD_START = 2'd1;
    localparam logic [1:0] TCMD_STOP  = 2'd2;

    localparam logic [1:0] METER_NONE = 2'd0;
    localparam logic [1:0] METER_TX   = 2'd1;
    localparam logic [1:0] METER_SCAN = 2'd2;

    localparam logic [2:0] MCODE_RX     = 3'd0;
    localparam logic [2:0] MCODE_TX     = 3'd1;
    localparam logic [2:0] MCODE_TSTART = 3'd2;
    localparam logic [2:0] MCODE_TWAIT  = 3'd3;
    localparam logic [2:0] MCODE_TRUN   = 3'd4;
    localparam logic [2:0] MCODE_SCAN   = 3'd5;
    localparam logic [2:0] MCODE_PWROFF = 3'd6;
    localparam logic [2:0] MCODE_OFF    = 3'd7;

    typedef enum logic [7:0] {
        MODE_RX     = 8'b0000_0001,
        MODE_TX     = 8'b0000_0010,
        MODE_TSTART = 8'b0000_0100,
        MODE_TWAIT  = 8'b0000_1000,
        MODE_TRUN   = 8'b0001_0000,
        MODE_SCAN   = 8'b0010_0000,
        MODE_PWROFF = 8'b0100_0000,
        MODE_OFF    = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [15:0] flow_timeout_ms;
        logic [15:0] idle_timeout_ms;
        logic [7:0]  report_divider;
        logic [7:0]  low_battery_level;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       func;
        logic [NOW_W-1:0] now_ms;
        logic             tx_flag;
        logic             tuner_done;
        logic             ext_power;
        logic [7:0]       battery_level;
    } item_t;

    typedef struct packed {
        logic       accepted;
        logic       low_power;
        logic       power_report;
        logic       idle_cmd;
        logic       flow_restart;
        logic       poweroff_cmd;
        logic [1:0] meter_update;
        logic       tuner_finished;
        logic [1:0] tuner_cmd;
        logic [1:0] tx_notify;
        logic [2:0] mode;
    } res_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        unique case (m)
            MODE_RX:     c = MCODE_RX;
            MODE_TX:     c = MCODE_TX;
            MODE_TSTART: c = MCODE_TSTART;
            MODE_TWAIT:  c = MCODE_TWAIT;
            MODE_TRUN:   c = MCODE_TRUN;
            MODE_SCAN:   c = MCODE_SCAN;
            MODE_PWROFF: c = MCODE_PWROFF;
            MODE_OFF:    c = MCODE_OFF;
            default:     c = MCODE_RX;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/tmc_cfg.sv =====
// Configuration register file for the transceiver mode controller.
`default_nettype none

module tmc_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output tmc_pkg::cfg_t      cfg
);
    import tmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLOW_TIMEOUT: cfg_next.flow_timeout_ms   = cfg_data;
                CFG_IDLE_TIMEOUT: cfg_next.idle_timeout_ms   = cfg_data;
                CFG_REPORT_DIV:   cfg_next.report_divider    = cfg_data[7:0];
                CFG_LOW_BATTERY:  cfg_next.low_battery_level = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_timeout_ms   <= FLOW_TIMEOUT_RST;
            cfg_reg.idle_timeout_ms   <= IDLE_TIMEOUT_RST;
            cfg_reg.report_divider    <= REPORT_DIV_RST;
            cfg_reg.low_battery_level <= LOW_BATTERY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/tmc_core.sv =====
// Mode machine, timers and report divider: state registers and per-item logic.
`default_nettype none

module tmc_core #(
    parameter int TIME_BITS = tmc_pkg::TIME_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  tmc_pkg::item_t item,
    input  tmc_pkg::cfg_t  cfg,
    output tmc_pkg::res_t  res
);
    import tmc_pkg::*;

    // now_ms is 32 bits wide, so stored times never need more
    localparam int TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

    mode_t         mode_reg, mode_next;
    logic [TW-1:0] lpt_reg, lpt_next;
    logic [TW-1:0] lat_reg, lat_next;
    logic [7:0]    rcnt_reg, rcnt_next;

    logic [TW-1:0] now;
    logic [TW-1:0] lpt_eff;
    logic [TW-1:0] lat_mid;
    logic [TW-1:0] flow_to;
    logic [TW-1:0] idle_to;
    logic [8:0]    cnt;
    logic          tick;
    res_t          r;

    assign now     = item.now_ms[TW-1:0];
    assign flow_to = TW'(cfg.flow_timeout_ms);
    assign idle_to = TW'(cfg.idle_timeout_ms);
    assign tick    = (item.func == FUNC_PACKET) || (item.func == FUNC_EMPTY);
    assign lpt_eff = (now < lpt_reg) ? now : lpt_reg;
    assign cnt     = {1'b0, rcnt_reg} + 9'd1;

    always_comb
    begin
        mode_next = mode_reg;
        lpt_next  = lpt_reg;
        lat_mid   = lat_reg;
        rcnt_next = rcnt_reg;
        r         = '0;
        r.tx_notify    = NOTIFY_NONE;
        r.tuner_cmd    = TCMD_NONE;
        r.meter_update = METER_NONE;

        unique case (item.func)
            FUNC_PACKET:
            begin
                lpt_next = now;
                if (cnt > {1'b0, cfg.report_divider})
                begin
                    rcnt_next      = '0;
                    r.power_report = 1'b1;
                    r.low_power    = !item.ext_power &&
                                     (item.battery_level <= cfg.low_battery_level);
                end
                else
                begin
                    rcnt_next = cnt[7:0];
                end
                unique case (mode_reg)
                    MODE_RX:
                    begin
                        if (item.tx_flag)
                        begin
                            mode_next   = MODE_TX;
                            r.tx_notify = NOTIFY_TX;
                        end
                    end
                    MODE_TX:
                    begin
                        if (!item.tx_flag)
                        begin
                            mode_next   = MODE_RX;
                            r.tx_notify = NOTIFY_RX;
                        end
                        else
                        begin
                            r.meter_update = METER_TX;
                        end
                    end
                    MODE_TSTART:
                    begin
                        r.tuner_cmd = TCMD_START;
                        lat_mid     = now;
                        mode_next   = MODE_TWAIT;
                    end
                    MODE_TWAIT:
                    begin
                        if (item.tx_flag)
                        begin
                            r.tx_notify = NOTIFY_TX;
                            mode_next   = MODE_TRUN;
                        end
                    end
                    MODE_TRUN:
                    begin
                        if (item.tuner_done && !item.tx_flag)
                        begin
                            r.tuner_finished = 1'b1;
                            r.tuner_cmd      = TCMD_STOP;
                            r.tx_notify      = NOTIFY_RX;
                            lat_mid          = now;
                            mode_next        = MODE_RX;
                        end
                        else if (item.tx_flag)
                        begin
                            r.meter_update = METER_TX;
                        end
                    end
                    MODE_SCAN:
                    begin
                        r.meter_update = METER_SCAN;
                    end
                    MODE_PWROFF:
                    begin
                        r.poweroff_cmd = 1'b1;
                        mode_next      = MODE_OFF;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            FUNC_EMPTY:
            begin
                if ((now - lpt_eff) > flow_to)
                begin
                    lpt_next       = now;
                    r.flow_restart = 1'b1;
                end
                else
                begin
                    lpt_next = lpt_eff;
                end
            end
            FUNC_START_TUN:
            begin
                if (mode_reg == MODE_RX)
                    mode_next = MODE_TSTART;
            end
            FUNC_START_SCN:
            begin
                if (mode_reg == MODE_RX)
                begin
                    mode_next  = MODE_SCAN;
                    r.accepted = 1'b1;
                    lat_mid    = now;
                end
            end
            FUNC_STOP_SCN:
            begin
                if (mode_reg == MODE_SCAN)
                begin
                    mode_next = MODE_RX;
                    lat_mid   = now;
                end
            end
            FUNC_POWER_OFF:
            begin
                mode_next = MODE_PWROFF;
            end
            FUNC_ACCESS:
            begin
                lat_mid = now;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // idle check after every tick, on the mode and access time it leaves
        lat_next = lat_mid;
        if (tick && (mode_next == MODE_RX) && (now >= lat_mid) &&
            ((now - lat_mid) > idle_to))
        begin
            r.idle_cmd = 1'b1;
            lat_next   = now;
        end

        r.mode = mode_code(mode_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RX;
            lpt_reg  <= '0;
            lat_reg  <= '0;
            rcnt_reg <= '0;
        end
        else if (en)
        begin
            mode_reg <= mode_next;
            lpt_reg  <= lpt_next;
            lat_reg  <= lat_next;
            rcnt_reg <= rcnt_next;
        end
    end

    assign res = r;

    a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(mode_reg))
        else $error("mode register lost its one-hot code");

    a_power_off: assert property (@(posedge clk) disable iff (!rst_n)
        en && (item.func == FUNC_POWER_OFF) |=> mode_reg == MODE_PWROFF)
        else $error("power off request did not reach poweroff mode");

    a_idle_rx: assert property (@(posedge clk) disable iff (!rst_n)
        en && r.idle_cmd |=> (mode_reg == MODE_RX) && (lat_reg == $past(now)))
        else $error("idle command outside receive or access time not restarted");

    a_low_power: assert property (@(posedge clk) disable iff (!rst_n)
        r.low_power |-> r.power_report && (item.func == FUNC_PACKET))
        else $error("low power flagged without a power report");

endmodule

`default_nettype wire

// ===== design/transceiver_mode_controller_unit.sv =====
// Top level: stream input register, controller core and result register.
//
// Usage
//   Input items arrive on s_axis_*; s_axis_tuser carries the event code and
//   s_axis_tdata the time stamp and the packet fields. Each accepted item
//   gives exactly one result item on m_axis_*, in order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); a
//   write takes effect at the clock edge where cfg_we is high. Write only
//   while no item is in flight.
//   Path: the accepting edge loads the input register; the result register
//   is loaded through the mode logic when the item advances, which waits
//   while a held result has not been taken.
//   Throughput: one item per cycle while m_axis_tready is high, set by the
//   combinational mode, timer and report counter update between the registers.
//   Reset: the mode returns to receive, both time stamps and the report count
//   clear, the configuration registers take their default values and both
//   stages empty.
//   Stall: while m_axis_tready is low the result holds; one more item waits
//   in the input register, then s_axis_tready drops until the result is taken.
`default_nettype none

module transceiver_mode_controller_unit #(
    parameter int TIME_BITS = tmc_pkg::TIME_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [31:0] now_ms, [32] tx_flag, [33] tuner_done, [34] ext_power,
    // [42:35] battery_level, [47:43] zero
    input  wire logic [47:0] s_axis_tdata,
    // [2:0] func
    input  wire logic [2:0]  s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] mode, [4:3] tx_notify, [6:5] tuner_cmd, [7] tuner_finished,
    // [9:8] meter_update, [10] poweroff_cmd, [11] flow_restart, [12] idle_cmd,
    // [13] power_report, [14] low_power, [15] accepted
    output      logic [15:0] m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import tmc_pkg::*;

    logic  in_valid_reg, in_valid_next;
    logic  out_valid_reg, out_valid_next;
    item_t item_reg;
    res_t  res_reg;
    res_t  res;
    cfg_t  cfg;
    logic  s_fire;
    logic  advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.func          <= s_axis_tuser;
            item_reg.now_ms        <= s_axis_tdata[31:0];
            item_reg.tx_flag       <= s_axis_tdata[32];
            item_reg.tuner_done    <= s_axis_tdata[33];
            item_reg.ext_power     <= s_axis_tdata[34];
            item_reg.battery_level <= s_axis_tdata[42:35];
        end
        if (advance)
            res_reg <= res;
    end

    tmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tmc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("waiting input item dropped or overwritten");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

// ===== sim/tb_transceiver_mode_controller_unit.sv =====
// Self-checking testbench for the transceiver mode controller: directed table, then random phases.
`timescale 1ns / 100ps

module tb_transceiver_mode_controller_unit;

    import tmc_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] now_ms;
        logic        tx_flag;
        logic        tuner_done;
        logic        ext_power;
        logic [7:0]  battery_level;
        bit          typed;
        res_t        want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] now_ms, [32] tx_flag, [33] tuner_done, [34] ext_power,
    // [42:35] battery_level, [47:43] zero
    logic [47:0] s_axis_tdata = '0;
    // [2:0] func
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] mode, [4:3] tx_notify, [6:5] tuner_cmd, [7] tuner_finished,
    // [9:8] meter_update, [10] poweroff_cmd, [11] flow_restart, [12] idle_cmd,
    // [13] power_report, [14] low_power, [15] accepted
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // controller state as the block should hold it
    logic [2:0]  mode_now = MCODE_RX;
    logic [31:0] last_pkt_ms = '0;
    logic [31:0] last_access_ms = '0;
    logic [7:0]  pkt_count = '0;
    logic [15:0] flow_to = FLOW_TIMEOUT_RST;
    logic [15:0] idle_to = IDLE_TIMEOUT_RST;
    logic [7:0]  rpt_div = REPORT_DIV_RST;
    logic [7:0]  low_bat = LOW_BATTERY_RST;

    res_t        expected_results[$];
    stim_row_t   bench_rows[$];
    bit          row_typed = 1'b0;
    res_t        row_want = '0;
    int          mismatch_count = 0;
    int          burst_left = 0;
    int unsigned cycle_count = 0;
    logic [31:0] stall_tick = '0;
    int          stall_style = 0;
    logic [31:0] clock_ms = '0;
    logic        keyed = 1'b0;

    transceiver_mode_controller_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Advance the controller by one event and return the result it must give.
    task automatic advance_controller(input logic [2:0] func, input logic [31:0] now,
                                      input logic tx, input logic tdone, input logic ext,
                                      input logic [7:0] bat, output res_t r);
        logic [8:0]  cnt;
        logic [31:0] diff;
        logic        tick;
        r = '0;
        tick = (func == FUNC_PACKET) || (func == FUNC_EMPTY);
        if (tick && now < last_pkt_ms)
            last_pkt_ms = now;
        case (func)
            FUNC_PACKET:
            begin
                cnt = {1'b0, pkt_count} + 9'd1;
                last_pkt_ms = now;
                if (cnt > {1'b0, rpt_div})
                begin
                    pkt_count = '0;
                    r.power_report = 1'b1;
                    r.low_power = !ext && (bat <= low_bat);
                end
                else
                begin
                    pkt_count = cnt[7:0];
                end
                case (mode_now)
                    MCODE_RX:
                        if (tx)
                        begin
                            mode_now = MCODE_TX;
                            r.tx_notify = NOTIFY_TX;
                        end
                    MCODE_TX:
                        if (!tx)
                        begin
                            mode_now = MCODE_RX;
                            r.tx_notify = NOTIFY_RX;
                        end
                        else
                        begin
                            r.meter_update = METER_TX;
                        end
                    MCODE_TSTART:
                    begin
                        r.tuner_cmd = TCMD_START;
                        last_access_ms = now;
                        mode_now = MCODE_TWAIT;
                    end
                    MCODE_TWAIT:
                        if (tx)
                        begin
                            r.tx_notify = NOTIFY_TX;
                            mode_now = MCODE_TRUN;
                        end
                    MCODE_TRUN:
                        if (tdone && !tx)
                        begin
                            r.tuner_finished = 1'b1;
                            r.tuner_cmd = TCMD_STOP;
                            r.tx_notify = NOTIFY_RX;
                            last_access_ms = now;
                            mode_now = MCODE_RX;
                        end
                        else if (tx)
                        begin
                            r.meter_update = METER_TX;
                        end
                    MCODE_SCAN:
                        r.meter_update = METER_SCAN;
                    MCODE_PWROFF:
                    begin
                        r.poweroff_cmd = 1'b1;
                        mode_now = MCODE_OFF;
                    end
                    default: ;
                endcase
            end
            FUNC_EMPTY:
            begin
                diff = now - last_pkt_ms;
                if (diff > {16'b0, flow_to})
                begin
                    last_pkt_ms = now;
                    r.flow_restart = 1'b1;
                end
            end
            FUNC_START_TUN:
                if (mode_now == MCODE_RX)
                    mode_now = MCODE_TSTART;
            FUNC_START_SCN:
                if (mode_now == MCODE_RX)
                begin
                    mode_now = MCODE_SCAN;
                    r.accepted = 1'b1;
                    last_access_ms = now;
                end
            FUNC_STOP_SCN:
                if (mode_now == MCODE_SCAN)
                begin
                    mode_now = MCODE_RX;
                    last_access_ms = now;
                end
            FUNC_POWER_OFF:
                mode_now = MCODE_PWROFF;
            FUNC_ACCESS:
                last_access_ms = now;
            default: ;
        endcase
        diff = now - last_access_ms;
        if (tick && mode_now == MCODE_RX && now >= last_access_ms && diff > {16'b0, idle_to})
        begin
            r.idle_cmd = 1'b1;
            last_access_ms = now;
        end
        r.mode = mode_now;
    endtask

    always @(posedge clk)
    begin : scoreboard
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_controller(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[32],
                                   s_axis_tdata[33], s_axis_tdata[34], s_axis_tdata[42:35],
                                   want);
                if (row_typed)
                    want = row_want;
                expected_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no item pending", got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("mode", 32'(got.mode), 32'(want.mode));
                    check_field("tx_notify", 32'(got.tx_notify), 32'(want.tx_notify));
                    check_field("tuner_cmd", 32'(got.tuner_cmd), 32'(want.tuner_cmd));
                    check_field("tuner_finished", 32'(got.tuner_finished),
                                32'(want.tuner_finished));
                    check_field("meter_update", 32'(got.meter_update),
                                32'(want.meter_update));
                    check_field("poweroff_cmd", 32'(got.poweroff_cmd),
                                32'(want.poweroff_cmd));
                    check_field("flow_restart", 32'(got.flow_restart),
                                32'(want.flow_restart));
                    check_field("idle_cmd", 32'(got.idle_cmd), 32'(want.idle_cmd));
                    check_field("power_report", 32'(got.power_report),
                                32'(want.power_report));
                    check_field("low_power", 32'(got.low_power), 32'(want.low_power));
                    check_field("accepted", 32'(got.accepted), 32'(want.accepted));
                end
            end
        end
    end

    // receiver: switch between four stall styles, picked at random
    always @(negedge clk)
    begin
        stall_tick = stall_tick + 32'd1;
        if (stall_tick[5:0] == 6'd0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = 1'($urandom_range(0, 1));
            2:       m_axis_tready = (stall_tick[1:0] == 2'd0);
            default: m_axis_tready = stall_tick[3];
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_row(input logic [2:0] func, input logic [31:0] now, input logic tx,
                           input logic tdone, input logic ext, input logic [7:0] bat,
                           input bit typed, input res_t want);
        stim_row_t row;
        row.func = func;
        row.now_ms = now;
        row.tx_flag = tx;
        row.tuner_done = tdone;
        row.ext_power = ext;
        row.battery_level = bat;
        row.typed = typed;
        row.want = want;
        bench_rows.push_back(row);
    endtask

    // Present one item, with a random gap between bursts; return once it is taken.
    task automatic issue(input logic [2:0] func, input logic [31:0] now, input logic tx,
                         input logic tdone, input logic ext, input logic [7:0] bat,
                         input bit typed, input res_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = func;
        s_axis_tdata = {5'b0, bat, ext, tdone, tx, now};
        row_typed = typed;
        row_want = want;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Hold the sender until every pending result has come out.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            CFG_FLOW_TIMEOUT: flow_to = value;
            CFG_IDLE_TIMEOUT: idle_to = value;
            CFG_REPORT_DIV:   rpt_div = value[7:0];
            CFG_LOW_BATTERY:  low_bat = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        res_t        quiet;
        res_t        restart;
        res_t        restart_idle;
        stim_row_t   row;
        logic [2:0]  func;
        logic [15:0] flow_v;
        logic [15:0] idle_v;
        logic [7:0]  div_v;
        logic [7:0]  bat_v;
        int          r;
        int          sent;
        int          phase_len;
        int          pkt_pct;
        bit          allow_off;

        quiet = '0;
        restart = '0;
        restart.flow_restart = 1'b1;
        restart_idle = restart;
        restart_idle.idle_cmd = 1'b1;

        // reset state; unused code, quiet tick, flow timeout, wrap of time, time going back
        add_row(FUNC_UNUSED,    32'd0,         1'b0, 1'b0, 1'b0, 8'd0,   1'b1, quiet);
        add_row(FUNC_EMPTY,     32'd0,         1'b0, 1'b0, 1'b0, 8'd0,   1'b1, quiet);
        add_row(FUNC_EMPTY,     32'd301,       1'b0, 1'b0, 1'b0, 8'd0,   1'b1, restart);
        add_row(FUNC_EMPTY,     32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd0,   1'b1, restart_idle);
        add_row(FUNC_EMPTY,     32'd100,       1'b0, 1'b0, 1'b0, 8'd0,   1'b1, quiet);
        add_row(FUNC_ACCESS,    32'd200,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        // transmit and back
        add_row(FUNC_PACKET,    32'd300,       1'b1, 1'b0, 1'b1, 8'd255, 1'b0, quiet);
        add_row(FUNC_PACKET,    32'd310,       1'b1, 1'b0, 1'b1, 8'd255, 1'b0, quiet);
        add_row(FUNC_PACKET,    32'd320,       1'b0, 1'b0, 1'b1, 8'd255, 1'b0, quiet);
        // tuner run, with requests in the wrong mode
        add_row(FUNC_START_TUN, 32'd330,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        add_row(FUNC_START_SCN, 32'd340,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        add_row(FUNC_STOP_SCN,  32'd345,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        add_row(FUNC_PACKET,    32'd350,       1'b0, 1'b0, 1'b1, 8'd100, 1'b0, quiet);
        add_row(FUNC_START_TUN, 32'd355,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        add_row(FUNC_PACKET,    32'd360,       1'b1, 1'b0, 1'b1, 8'd100, 1'b0, quiet);
        add_row(FUNC_PACKET,    32'd370,       1'b1, 1'b1, 1'b1, 8'd100, 1'b0, quiet);
        add_row(FUNC_PACKET,    32'd380,       1'b0, 1'b1, 1'b1, 8'd100, 1'b0, quiet);
        // scan
        add_row(FUNC_START_SCN, 32'd390,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        add_row(FUNC_PACKET,    32'd400,       1'b0, 1'b0, 1'b1, 8'd100, 1'b0, quiet);
        add_row(FUNC_STOP_SCN,  32'd410,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        // battery around the low level, report on the twelfth packet
        add_row(FUNC_PACKET,    32'd420,       1'b0, 1'b0, 1'b0, 8'd60,  1'b0, quiet);
        add_row(FUNC_PACKET,    32'd430,       1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);
        add_row(FUNC_PACKET,    32'd440,       1'b0, 1'b0, 1'b0, 8'd61,  1'b0, quiet);
        add_row(FUNC_PACKET,    32'd450,       1'b0, 1'b0, 1'b0, 8'd60,  1'b0, quiet);
        // flow restart and idle together
        add_row(FUNC_EMPTY,     32'd5000,      1'b0, 1'b0, 1'b0, 8'd0,   1'b0, quiet);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (bench_rows[i])
        begin
            row = bench_rows[i];
            issue(row.func, row.now_ms, row.tx_flag, row.tuner_done, row.ext_power,
                  row.battery_level, row.typed, row.want);
        end

        clock_ms = 32'd5000;
        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    flow_v = 16'd1;
                    idle_v = 16'd1;
                    div_v  = 8'd0;
                    bat_v  = 8'd0;
                end
                1:
                begin
                    flow_v = 16'hFFFF;
                    idle_v = 16'hFFFF;
                    div_v  = 8'hFF;
                    bat_v  = 8'hFF;
                end
                default:
                begin
                    flow_v = 16'($urandom_range(1, 2000));
                    idle_v = 16'($urandom_range(1, 8000));
                    div_v  = 8'($urandom_range(0, 20));
                    bat_v  = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_FLOW_TIMEOUT, flow_v);
            write_reg(CFG_IDLE_TIMEOUT, idle_v);
            write_reg(CFG_REPORT_DIV, {8'b0, div_v});
            write_reg(CFG_LOW_BATTERY, {8'b0, bat_v});
            // run across the wrap of the millisecond counter
            if (phase == 3)
                clock_ms = 32'hFFFF_F000 + $urandom_range(0, 3000);
            // the widest divider needs 256 packets to fire
            phase_len = (phase == 1) ? 450 : 200;
            pkt_pct = (phase == 1) ? 65 : 45;

            sent = 0;
            while (sent < phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    clock_ms = clock_ms + $urandom_range(0, 40);
                else if (r < 80)
                    clock_ms = clock_ms + $urandom_range(0, 400);
                else if (r < 92)
                    clock_ms = clock_ms + $urandom_range(0, 4000);
                else if (r < 97)
                    clock_ms = clock_ms + $urandom_range(0, 80000);
                else if (r < 99)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms - $urandom_range(1, 500);

                if ($urandom_range(0, 99) < 12)
                    keyed = !keyed;

                // power off sticks for good, so keep it to the tail of the run
                allow_off = (phase == 4) && (sent >= 150);
                r = $urandom_range(0, 99);
                if (r < pkt_pct)
                    func = FUNC_PACKET;
                else if (r < pkt_pct + 12)
                    func = FUNC_EMPTY;
                else if (r < pkt_pct + 17)
                    func = FUNC_START_TUN;
                else if (r < pkt_pct + 21)
                    func = FUNC_START_SCN;
                else if (r < pkt_pct + 26)
                    func = FUNC_STOP_SCN;
                else if (r < pkt_pct + 32)
                    func = FUNC_ACCESS;
                else if (r < pkt_pct + 34)
                    func = FUNC_UNUSED;
                else if (allow_off && r >= 95)
                    func = FUNC_POWER_OFF;
                else
                    func = FUNC_EMPTY;

                if (func != FUNC_UNUSED)
                    sent++;
                issue(func, clock_ms, keyed, ($urandom_range(0, 3) == 0),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, quiet);

                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
